[hw/rtl/ir_pulse_distance_decoder_defines.svh]
// ----------------------------------------------------------------------------
// IR pulse-distance decoder assertion macros
// Property shorthands for the checker of this block.
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_DISTANCE_DECODER_DEFINES_SVH
`define IR_PULSE_DISTANCE_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define IRD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("IR decoder assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define IRD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("IR decoder assertion failed");

`endif

[hw/rtl/ird_pkg.sv]
// ----------------------------------------------------------------------------
// IR pulse-distance decoder package
// Widths, register indexes, reset values, word types and helper functions.
// ----------------------------------------------------------------------------
package ird_pkg;

    // Sizes of the interval timer and the frame shift register.
    localparam int TIMER_WIDTH    = 16;
    localparam int MAX_FRAME_BITS = 32;
    localparam int CFG_WIDTH      = 16;
    localparam int FB_WIDTH       = 6;
    localparam int WORD_WIDTH     = 32;
    localparam int CFG_ADDR_W     = 3;
    localparam int BITS_W         = $clog2(MAX_FRAME_BITS + 1);
    localparam int IDX_W          = $clog2(MAX_FRAME_BITS);

    // Register indexes on the configuration port.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TIMEOUT    = 3'd0,
        REG_LEADER_MIN = 3'd1,
        REG_LEADER_MAX = 3'd2,
        REG_SHORT_MIN  = 3'd3,
        REG_SHORT_MAX  = 3'd4,
        REG_LONG_MIN   = 3'd5,
        REG_LONG_MAX   = 3'd6,
        REG_FRAME_BITS = 3'd7
    } cfg_idx_t;

    // Register reset values.
    localparam logic [CFG_WIDTH-1:0] RST_TIMEOUT    = 16'd20000;
    localparam logic [CFG_WIDTH-1:0] RST_LEADER_MIN = 16'd17000;
    localparam logic [CFG_WIDTH-1:0] RST_LEADER_MAX = 16'd19000;
    localparam logic [CFG_WIDTH-1:0] RST_SHORT_MIN  = 16'd1940;
    localparam logic [CFG_WIDTH-1:0] RST_SHORT_MAX  = 16'd2540;
    localparam logic [CFG_WIDTH-1:0] RST_LONG_MIN   = 16'd6460;
    localparam logic [CFG_WIDTH-1:0] RST_LONG_MAX   = 16'd7060;
    localparam logic [FB_WIDTH-1:0]  RST_FRAME_BITS = 6'd32;

    // Input word: a timer tick or a pin edge.
    typedef struct packed {
        logic cmd;
        logic pin_level;
    } ird_in_t;

    // Output word.
    typedef struct packed {
        logic                  frame_valid;
        logic [WORD_WIDTH-1:0] frame_word;
        logic                  receiving;
    } ird_out_t;

    // Current register values.
    typedef struct packed {
        logic [CFG_WIDTH-1:0] timeout_ticks;
        logic [CFG_WIDTH-1:0] leader_min;
        logic [CFG_WIDTH-1:0] leader_max;
        logic [CFG_WIDTH-1:0] short_min;
        logic [CFG_WIDTH-1:0] short_max;
        logic [CFG_WIDTH-1:0] long_min;
        logic [CFG_WIDTH-1:0] long_max;
        logic [FB_WIDTH-1:0]  frame_bits;
    } ird_cfg_t;

    // Frame length write, which reloads the bit counter and clears the word.
    typedef struct packed {
        logic                load;
        logic [FB_WIDTH-1:0] value;
    } ird_fb_load_t;

    // Frame length as used: zero counts as one, large values are clamped.
    function automatic logic [BITS_W-1:0] eff_bits(input logic [FB_WIDTH-1:0] fb);
        logic [BITS_W-1:0] res;
        if (fb == '0)
            res = BITS_W'(1);
        else if (int'(fb) > MAX_FRAME_BITS)
            res = BITS_W'(MAX_FRAME_BITS);
        else
            res = BITS_W'(fb);
        return res;
    endfunction

    // Strict window test: lo < v < hi.
    function automatic logic in_window(input logic [TIMER_WIDTH-1:0] v,
                                       input logic [CFG_WIDTH-1:0]   lo,
                                       input logic [CFG_WIDTH-1:0]   hi);
        return (v > lo) && (v < hi);
    endfunction

endpackage

[hw/rtl/ird_cfg.sv]
// ----------------------------------------------------------------------------
// IR decoder configuration registers
// Holds the timing windows, the timeout and the frame length.
// ----------------------------------------------------------------------------
module ird_cfg
    import ird_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_WIDTH-1:0]  cfg_data,
    output ird_cfg_t              cfg,
    output ird_fb_load_t          fb_load
);

    ird_cfg_t cfg_reg;
    ird_cfg_t cfg_next;

    // Write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                REG_TIMEOUT:    cfg_next.timeout_ticks = cfg_data;
                REG_LEADER_MIN: cfg_next.leader_min    = cfg_data;
                REG_LEADER_MAX: cfg_next.leader_max    = cfg_data;
                REG_SHORT_MIN:  cfg_next.short_min     = cfg_data;
                REG_SHORT_MAX:  cfg_next.short_max     = cfg_data;
                REG_LONG_MIN:   cfg_next.long_min      = cfg_data;
                REG_LONG_MAX:   cfg_next.long_max      = cfg_data;
                REG_FRAME_BITS: cfg_next.frame_bits    = cfg_data[FB_WIDTH-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    // Register bank.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks <= RST_TIMEOUT;
            cfg_reg.leader_min    <= RST_LEADER_MIN;
            cfg_reg.leader_max    <= RST_LEADER_MAX;
            cfg_reg.short_min     <= RST_SHORT_MIN;
            cfg_reg.short_max     <= RST_SHORT_MAX;
            cfg_reg.long_min      <= RST_LONG_MIN;
            cfg_reg.long_max      <= RST_LONG_MAX;
            cfg_reg.frame_bits    <= RST_FRAME_BITS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg           = cfg_reg;
    assign fb_load.load  = cfg_we && (cfg_idx_t'(cfg_addr) == REG_FRAME_BITS);
    assign fb_load.value = cfg_data[FB_WIDTH-1:0];

endmodule

[hw/rtl/ird_core.sv]
// ----------------------------------------------------------------------------
// IR decoder core
// Leader check, interval timer, bit classification and the output register.
// ----------------------------------------------------------------------------
module ird_core
    import ird_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  ird_cfg_t     cfg,
    input  ird_fb_load_t fb_load,
    input  logic         accept,
    input  ird_in_t      in_item,
    input  logic         out_take,
    output logic         out_valid,
    output ird_out_t     out_item
);

    logic                   active_reg, active_next;
    logic                   first_reg, first_next;
    logic                   second_reg, second_next;
    logic                   running_reg, running_next;
    logic [TIMER_WIDTH-1:0] count_reg, count_next;
    logic [TIMER_WIDTH-1:0] low_reg, low_next;
    logic [MAX_FRAME_BITS-1:0] shift_reg, shift_next;
    logic [BITS_W-1:0]      left_reg, left_next;
    logic                   out_valid_reg;
    ird_out_t               out_reg, out_next;

    logic [TIMER_WIDTH-1:0] lim;
    logic [TIMER_WIDTH-1:0] count_inc;
    logic [BITS_W-1:0]      left_fix;
    logic [BITS_W-1:0]      left_dec;
    logic                   data_bit;

    assign lim       = TIMER_WIDTH'(cfg.timeout_ticks);
    assign count_inc = count_reg + 1'b1;
    assign data_bit  = in_window(count_reg, cfg.long_min, cfg.long_max) &&
                       in_window(low_reg, cfg.short_min, cfg.short_max);
    assign left_fix  = ((left_reg == '0) || (int'(left_reg) > MAX_FRAME_BITS)) ?
                       eff_bits(cfg.frame_bits) : left_reg;
    assign left_dec  = left_fix - 1'b1;

    // Next state and result for one word.
    always_comb
    begin
        active_next  = active_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        running_next = running_reg;
        count_next   = count_reg;
        low_next     = low_reg;
        shift_next   = shift_reg;
        left_next    = left_reg;
        out_next.frame_valid = 1'b0;
        out_next.frame_word  = '0;

        if (!in_item.cmd)
        begin
            // Timer tick: count up and stop on expiry.
            if (running_reg)
            begin
                count_next = count_inc;
                if ((count_inc == lim) || (lim == '0))
                begin
                    running_next = 1'b0;
                    count_next   = '0;
                    active_next  = 1'b0;
                end
            end
        end
        else if (!active_reg)
        begin
            // Leader detection.
            if (!in_item.pin_level && !first_reg && !second_reg)
            begin
                first_next   = 1'b1;
                running_next = 1'b1;
                count_next   = '0;
            end
            else if (in_item.pin_level && first_reg && !second_reg)
            begin
                running_next = 1'b1;
                count_next   = '0;
                second_next  = in_window(count_reg, cfg.leader_min, cfg.leader_max);
            end
            else if (!in_item.pin_level && first_reg && second_reg)
            begin
                running_next = 1'b1;
                count_next   = '0;
                active_next  = in_window(count_reg, cfg.leader_min, cfg.leader_max);
                first_next   = 1'b0;
                second_next  = 1'b0;
                if (active_next)
                begin
                    shift_next = '0;
                    left_next  = eff_bits(cfg.frame_bits);
                end
            end
        end
        else if (in_item.pin_level)
        begin
            // Rising edge while receiving: keep the low time.
            low_next     = count_reg;
            running_next = 1'b1;
            count_next   = '0;
        end
        else
        begin
            // Falling edge while receiving: shift in one data bit, MSB first.
            running_next = 1'b1;
            count_next   = '0;
            left_next    = left_dec;
            shift_next[left_dec[IDX_W-1:0]] = shift_reg[left_dec[IDX_W-1:0]] | data_bit;
            if (left_dec == '0)
            begin
                out_next.frame_valid = 1'b1;
                out_next.frame_word  = WORD_WIDTH'(shift_next);
                shift_next = '0;
                low_next   = '0;
                left_next  = eff_bits(cfg.frame_bits);
            end
        end

        out_next.receiving = active_next;
    end

    // Decoder state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            first_reg   <= 1'b0;
            second_reg  <= 1'b0;
            running_reg <= 1'b0;
            count_reg   <= '0;
            low_reg     <= '0;
            shift_reg   <= '0;
            left_reg    <= eff_bits(RST_FRAME_BITS);
        end
        else if (fb_load.load)
        begin
            shift_reg <= '0;
            left_reg  <= eff_bits(fb_load.value);
        end
        else if (accept)
        begin
            active_reg  <= active_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
            running_reg <= running_next;
            count_reg   <= count_next;
            low_reg     <= low_next;
            shift_reg   <= shift_next;
            left_reg    <= left_next;
        end
    end

    // Output register: loads on accept, empties when the word is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_take)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

[hw/rtl/ir_pulse_distance_decoder.sv]
// ----------------------------------------------------------------------------
// IR pulse-distance frame decoder
// Decodes leader-plus-data IR frames from a stream of ticks and pin edges.
// ----------------------------------------------------------------------------
// Usage:
// The in channel carries one word per event: a timer tick (cmd = 0) or a
// receiver pin edge (cmd = 1) with the new pin level. Every accepted word
// produces exactly one word on the out channel, holding frame_valid, the
// frame when one completes, and the receiving flag after that event.
// An accepted word is shown on out in the next cycle. Throughput is one
// word per cycle; the decoder state updates in the accept cycle and the
// result sits in a single output register, so in_ready stays high while
// out_ready is high even when the register is full. When the receiver
// stalls, the output register holds its word and in_ready drops until it is
// taken. Reset clears the decoder state, loads the default timing windows
// and a 32-bit frame length, and empties the output register. Configuration
// is written through cfg_we/cfg_addr/cfg_data, one register per cycle, only
// while no word is in flight, a rule the user must keep as the block does not
// enforce it; writing the frame length restarts the bit count.
// ----------------------------------------------------------------------------
module ir_pulse_distance_decoder
    import ird_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  ird_in_t               in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ird_out_t              out_word,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_WIDTH-1:0]  cfg_data
);

    ird_cfg_t     cfg;
    ird_fb_load_t fb_load;
    logic         accept;

    // Handshake: take a word whenever the output register is free or leaving.
    assign in_ready = !out_valid || out_ready;
    assign accept   = in_valid && in_ready;

    ird_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg),
        .fb_load  (fb_load)
    );

    ird_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .fb_load   (fb_load),
        .accept    (accept),
        .in_item   (in_word),
        .out_take  (out_ready),
        .out_valid (out_valid),
        .out_item  (out_word)
    );

endmodule

[hw/rtl/ird_checker.sv]
// ----------------------------------------------------------------------------
// IR decoder port checker
// Watches the top-level ports for flow and result consistency.
// ----------------------------------------------------------------------------
`include "ir_pulse_distance_decoder_defines.svh"

module ird_checker
    import ird_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input ird_out_t              out_word
);

    // Every accepted word yields a result word on the next cycle.
    `IRD_ASSERT_NEXT(a_accept_gives_result, in_valid && in_ready, out_valid)

    // An empty output register never holds off the sender.
    `IRD_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

    // Without a completed frame the frame field reads zero.
    `IRD_ASSERT_NOW(a_word_zero_without_frame, out_valid && !out_word.frame_valid,
                    out_word.frame_word == '0)

    // A stalled result word stays put.
    `IRD_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready,
                     out_valid && $stable(out_word))

endmodule

bind ir_pulse_distance_decoder ird_checker u_ird_checker (.*);
